FILE: hw/rtl/cntsem_pkg.sv
`timescale 1ns / 1ps

package cntsem_pkg;

    localparam int MAX_WAITERS    = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int IDX_W          = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

    localparam int ACT_W = 2;
    localparam int TID_W = 8;
    localparam int TMO_W = 16;
    localparam int EV_W  = 3;
    localparam int CNT_W = 16;
    localparam int INIT_W = 15;

    localparam logic [ACT_W-1:0] ACT_WAIT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SIGNAL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

    localparam logic [EV_W-1:0] EV_GRANTED = 3'd0;
    localparam logic [EV_W-1:0] EV_BLOCKED = 3'd1;
    localparam logic [EV_W-1:0] EV_SIGNAL  = 3'd2;
    localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd3;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd4;
    localparam logic [EV_W-1:0] EV_NOTHING = 3'd5;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sd32767;

    typedef struct packed {
        logic                      valid;
        logic                      expired;
        logic                      timed;
        logic [TMO_W-1:0]          timer;
        logic [THREAD_ID_BITS-1:0] thread;
    } cell_data_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic shift;
        logic tick;
    } cell_ctl_t;

endpackage

FILE: hw/rtl/cntsem_cell.sv
`timescale 1ns / 1ps

module cntsem_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cntsem_pkg::cell_ctl_t  ctl,
    input  cntsem_pkg::cell_data_t wdata,
    input  cntsem_pkg::cell_data_t nbr,
    output cntsem_pkg::cell_data_t data
);

    cntsem_pkg::cell_data_t d_reg;
    cntsem_pkg::cell_data_t d_next;
    logic [cntsem_pkg::TMO_W-1:0] timer_dec;

    always_comb
    begin
        d_next    = d_reg;
        timer_dec = (d_reg.timer != '0) ? d_reg.timer - 1'b1 : d_reg.timer;
        if (ctl.clr)
        begin
            d_next.valid   = 1'b0;
            d_next.expired = 1'b0;
        end
        else if (ctl.load)
        begin
            d_next = wdata;
        end
        else if (ctl.shift)
        begin
            d_next = nbr;
        end
        else if (ctl.tick && d_reg.valid && d_reg.timed)
        begin
            d_next.timer   = timer_dec;
            d_next.expired = (timer_dec == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else
        begin
            d_reg <= d_next;
        end
    end

    assign data = d_reg;

endmodule

FILE: hw/rtl/counting_semaphore_with_timeout_core.sv
`timescale 1ns / 1ps

// Counting semaphore with a queue of up to MAX_WAITERS blocked threads held in
// a row of cells, oldest in cell 0. A wait, a signal or an unused action gives
// one transaction on the output; a tick first counts down every timed waiter
// and then gives one transaction for each waiter whose timer ran out (newest
// first, each removed by shifting the cells above it down), or the single
// "nothing" result when none ran out. Input is taken only while no tick is
// being worked off and the output register is free or draining. A write on
// cfg_we loads the count and empties the queue at once.

module counting_semaphore_with_timeout_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,    // initial_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // thread_id[7:0], timeout[23:8]
    input  logic [1:0]  s_tuser,      // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // woken_thread[7:0], count_now[23:8]
    output logic [2:0]  m_tuser,      // event_res
    output logic        m_tlast
);

    localparam int N = cntsem_pkg::MAX_WAITERS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic state_reg;
    logic state_next;

    logic signed [cntsem_pkg::CNT_W-1:0] count_reg;
    logic signed [cntsem_pkg::CNT_W-1:0] count_next;
    logic signed [cntsem_pkg::CNT_W-1:0] count_inc;

    logic                              m_tvalid_reg;
    logic                              m_tvalid_next;
    logic [cntsem_pkg::EV_W-1:0]       ev_reg;
    logic [cntsem_pkg::EV_W-1:0]       ev_next;
    logic [cntsem_pkg::TID_W-1:0]      tid_reg;
    logic [cntsem_pkg::TID_W-1:0]      tid_next;
    logic signed [cntsem_pkg::CNT_W-1:0] cnt_out_reg;
    logic signed [cntsem_pkg::CNT_W-1:0] cnt_out_next;
    logic                              last_reg;
    logic                              last_next;

    cntsem_pkg::cell_data_t cell_q   [N];
    cntsem_pkg::cell_ctl_t  cell_ctl [N];
    cntsem_pkg::cell_data_t wdata;

    logic [N-1:0]                   valid_vec;
    logic [N-1:0]                   exp_vec;
    logic [N-1:0]                   hi_onehot;
    logic [cntsem_pkg::IDX_W-1:0]   hi_idx;
    logic                           any_exp;
    logic                           out_free;
    logic                           in_fire;
    logic [cntsem_pkg::ACT_W-1:0]   action;
    logic [cntsem_pkg::TID_W-1:0]   in_tid;
    logic [cntsem_pkg::TMO_W-1:0]   in_tmo;

    assign action  = s_tuser;
    assign in_tid  = s_tdata[7:0];
    assign in_tmo  = s_tdata[23:8];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    assign count_inc = (count_reg != cntsem_pkg::CNT_MAX) ? count_reg + 16'sd1 : count_reg;

    always_comb
    begin
        wdata.valid   = 1'b1;
        wdata.expired = 1'b0;
        wdata.timed   = (in_tmo != '0);
        wdata.timer   = in_tmo;
        wdata.thread  = in_tid[cntsem_pkg::THREAD_ID_BITS-1:0];
    end

    always_comb
    begin
        hi_idx = '0;
        for (int i = 0; i < N; i++)
        begin
            valid_vec[i] = cell_q[i].valid;
            exp_vec[i]   = cell_q[i].expired;
            if (cell_q[i].expired)
            begin
                hi_idx = cntsem_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < N; i++)
        begin
            hi_onehot[i] = (cntsem_pkg::IDX_W'(i) == hi_idx);
        end
        any_exp = |exp_vec;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ev_next       = ev_reg;
        tid_next      = tid_reg;
        cnt_out_next  = cnt_out_reg;
        last_next     = last_reg;
        for (int i = 0; i < N; i++)
        begin
            cell_ctl[i] = '0;
        end

        if (cfg_we)
        begin
            count_next = {1'b0, cfg_wdata};
            state_next = ST_IDLE;
            for (int i = 0; i < N; i++)
            begin
                cell_ctl[i].clr = 1'b1;
            end
        end
        else if (in_fire)
        begin
            tid_next  = '0;
            last_next = 1'b1;
            ev_next   = cntsem_pkg::EV_NOTHING;
            case (action)
                cntsem_pkg::ACT_WAIT:
                begin
                    tid_next = in_tid;
                    if (count_reg > 0)
                    begin
                        count_next = count_reg - 16'sd1;
                        ev_next    = cntsem_pkg::EV_GRANTED;
                    end
                    else if (valid_vec[N-1])
                    begin
                        ev_next = cntsem_pkg::EV_FULL;
                    end
                    else
                    begin
                        count_next = count_reg - 16'sd1;
                        ev_next    = cntsem_pkg::EV_BLOCKED;
                        for (int i = 0; i < N; i++)
                        begin
                            cell_ctl[i].load = !valid_vec[i] &&
                                               ((i == 0) || valid_vec[(i > 0) ? i - 1 : 0]);
                        end
                    end
                    m_tvalid_next = 1'b1;
                    cnt_out_next  = count_next;
                end
                cntsem_pkg::ACT_SIGNAL:
                begin
                    count_next = count_inc;
                    if (count_reg < 0 && valid_vec[0])
                    begin
                        ev_next  = cntsem_pkg::EV_SIGNAL;
                        tid_next = cntsem_pkg::TID_W'(cell_q[0].thread);
                        for (int i = 0; i < N; i++)
                        begin
                            cell_ctl[i].shift = 1'b1;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    cnt_out_next  = count_next;
                end
                cntsem_pkg::ACT_TICK:
                begin
                    state_next = ST_TICK;
                    for (int i = 0; i < N; i++)
                    begin
                        cell_ctl[i].tick = 1'b1;
                    end
                end
                default:
                begin
                    m_tvalid_next = 1'b1;
                    cnt_out_next  = count_reg;
                end
            endcase
        end
        else if (state_reg == ST_TICK && out_free)
        begin
            m_tvalid_next = 1'b1;
            if (any_exp)
            begin
                count_next   = count_inc;
                ev_next      = cntsem_pkg::EV_TIMEOUT;
                tid_next     = cntsem_pkg::TID_W'(cell_q[hi_idx].thread);
                cnt_out_next = count_inc;
                last_next    = ((exp_vec & ~hi_onehot) == '0);
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
                for (int i = 0; i < N; i++)
                begin
                    cell_ctl[i].shift = (cntsem_pkg::IDX_W'(i) >= hi_idx);
                end
            end
            else
            begin
                ev_next      = cntsem_pkg::EV_NOTHING;
                tid_next     = '0;
                cnt_out_next = count_reg;
                last_next    = 1'b1;
                state_next   = ST_IDLE;
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        cntsem_pkg::cell_data_t nbr;
        if (g == N - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_q[g + 1];
        end
        cntsem_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (cell_ctl[g]),
            .wdata (wdata),
            .nbr   (nbr),
            .data  (cell_q[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= 16'sd1;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg      <= ev_next;
        tid_reg     <= tid_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = ev_reg;
    assign m_tdata  = {cnt_out_reg, tid_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: hw/rtl/cntsem_checker.sv
`timescale 1ns / 1ps

module cntsem_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // hold the result while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cntsem_pkg::EV_TIMEOUT |-> m_tlast)
        else $error("non-timeout result without tlast");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != cntsem_pkg::ACT_TICK |=> m_tvalid)
        else $error("result missing one cycle after a non-tick transaction");

    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == cntsem_pkg::EV_GRANTED |-> !m_tdata[23])
        else $error("grant with negative count");

endmodule

bind counting_semaphore_with_timeout_core cntsem_checker u_cntsem_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
